### sv/debounced_limit_monitor_defines.svh
// ----------------------------------------------------------------------------
// debounced_limit_monitor_defines.svh
// Assertion macros used by the monitor's checker.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_LIMIT_MONITOR_DEFINES_SVH
`define DEBOUNCED_LIMIT_MONITOR_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define DLM_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("debounced_limit_monitor: assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define DLM_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("debounced_limit_monitor: assertion failed");

`endif

### sv/dlm_pkg.sv
// ----------------------------------------------------------------------------
// dlm_pkg
// Types and constants of the debounced limit monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dlm_pkg;

   localparam int SAMPLE_W       = 16;
   localparam int SETTLE_W       = 16;
   localparam int CNT_W          = 3;
   localparam int ALARM_DEBOUNCE = 4;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 16;

   // A low, high or cutoff limit at the most negative code turns the check off.
   localparam logic signed [SAMPLE_W-1:0] LIMIT_OFF = 16'sh8000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LOW_LIMIT       = 3'd0,
      REG_HIGH_LIMIT      = 3'd1,
      REG_CUTOFF_LIMIT    = 3'd2,
      REG_TARGET_LEVEL    = 3'd3,
      REG_WATCHED_CHANNEL = 3'd4,
      REG_SETTLE_NEEDED   = 3'd5,
      REG_RUN_DIRECTION   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       channel;
   } req_payload_type;

   typedef struct packed {
      logic charger_off;
      logic discharger_off;
      logic target_reached;
   } rsp_payload_type;

   // Per-sample control of one debounce counter.
   typedef struct packed {
      logic step;
      logic fail;
   } check_ctl_type;

endpackage

`default_nettype wire

### sv/dlm_check.sv
// ----------------------------------------------------------------------------
// dlm_check
// Saturating debounce counter for one limit check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlm_check #(
   parameter int DEBOUNCE = dlm_pkg::ALARM_DEBOUNCE
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dlm_pkg::check_ctl_type ctl,
   output logic                       hit
);

   localparam logic [dlm_pkg::CNT_W-1:0] FULL = dlm_pkg::CNT_W'(DEBOUNCE);

   logic [dlm_pkg::CNT_W-1:0] count_ff;
   logic [dlm_pkg::CNT_W-1:0] count_in;
   logic                      full;

   assign full = (count_ff >= FULL);
   assign hit  = ctl.step & ctl.fail & full;

   always_comb begin
      count_in = count_ff;
      if (ctl.step) begin
         if (!ctl.fail) begin
            count_in = '0;
         end else if (!full) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

### sv/debounced_limit_monitor.sv
// ----------------------------------------------------------------------------
// debounced_limit_monitor
// Debounced low/high/cutoff checks on channel 1 and a run-to-target counter.
// ----------------------------------------------------------------------------
//   channel | ports                        | beat
//   req     | req_valid/ready, req_data    | one sample with its channel
//   rsp     | rsp_valid/ready, rsp_data    | flags after that sample
//   csr     | csr_valid/ready, csr_index/data | one register write
//
// One sample per cycle unless a stalled result backs up the input register.
// The input register feeds the checks and state update; the result register
// holds the beat until taken. A stalled result stops the input register only
// when it is full. csr_ready is always high. Synchronous reset clears flags,
// counters and valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module debounced_limit_monitor #(
   parameter int ALARM_DEBOUNCE = dlm_pkg::ALARM_DEBOUNCE
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire dlm_pkg::req_payload_type         req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output dlm_pkg::rsp_payload_type              rsp_data,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [dlm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [dlm_pkg::CSR_DATA_W-1:0]   csr_data
);

   // configuration
   logic signed [dlm_pkg::SAMPLE_W-1:0] low_limit_ff;
   logic signed [dlm_pkg::SAMPLE_W-1:0] high_limit_ff;
   logic signed [dlm_pkg::SAMPLE_W-1:0] cutoff_limit_ff;
   logic signed [dlm_pkg::SAMPLE_W-1:0] target_level_ff;
   logic                                watched_channel_ff;
   logic [dlm_pkg::SETTLE_W-1:0]        settle_needed_ff;
   logic                                run_direction_ff;

   // pipeline
   logic                      in_valid_ff;
   dlm_pkg::req_payload_type  in_data_ff;
   logic                      out_valid_ff;
   dlm_pkg::rsp_payload_type  out_data_ff;
   dlm_pkg::rsp_payload_type  out_data_in;
   logic                      advance;
   logic                      csr_write;

   // state
   logic                         charger_off_ff;
   logic                         charger_off_in;
   logic                         discharger_off_ff;
   logic                         discharger_off_in;
   logic [dlm_pkg::SETTLE_W-1:0] settle_count_ff;
   logic [dlm_pkg::SETTLE_W-1:0] settle_count_in;

   dlm_pkg::check_ctl_type low_ctl;
   dlm_pkg::check_ctl_type high_ctl;
   dlm_pkg::check_ctl_type cut_ctl;
   logic                   low_hit;
   logic                   high_hit;
   logic                   cut_hit;
   logic                   ch1_step;
   logic                   watched;
   logic                   qualifies;
   logic                   reached;

   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // ---------------- limit checks (channel 1 only) ----------------
   assign ch1_step = advance & in_data_ff.channel;

   assign low_ctl.step  = ch1_step;
   assign low_ctl.fail  = (low_limit_ff != dlm_pkg::LIMIT_OFF) &
                          (in_data_ff.sample < low_limit_ff);
   assign high_ctl.step = ch1_step;
   assign high_ctl.fail = (high_limit_ff != dlm_pkg::LIMIT_OFF) &
                          (in_data_ff.sample > high_limit_ff);
   // a disabled cutoff freezes its counter
   assign cut_ctl.step  = ch1_step & (cutoff_limit_ff != dlm_pkg::LIMIT_OFF);
   assign cut_ctl.fail  = (in_data_ff.sample < cutoff_limit_ff);

   dlm_check #(.DEBOUNCE(ALARM_DEBOUNCE)) u_low_check (
      .clock (clock), .reset (reset), .ctl (low_ctl),  .hit (low_hit)
   );

   dlm_check #(.DEBOUNCE(ALARM_DEBOUNCE)) u_high_check (
      .clock (clock), .reset (reset), .ctl (high_ctl), .hit (high_hit)
   );

   dlm_check #(.DEBOUNCE(ALARM_DEBOUNCE)) u_cutoff_check (
      .clock (clock), .reset (reset), .ctl (cut_ctl),  .hit (cut_hit)
   );

   // passing low/high clears its flag; a fail below full keeps it; cutoff wins
   always_comb begin
      discharger_off_in = discharger_off_ff;
      charger_off_in    = charger_off_ff;
      if (ch1_step) begin
         discharger_off_in = (low_ctl.fail & discharger_off_ff) | low_hit | cut_hit;
         charger_off_in    = (high_ctl.fail & charger_off_ff) | high_hit | cut_hit;
      end
   end

   // ---------------- run-to-target ----------------
   assign watched   = (in_data_ff.channel == watched_channel_ff);
   assign qualifies = run_direction_ff ? (in_data_ff.sample <= target_level_ff)
                                       : (in_data_ff.sample >= target_level_ff);

   always_comb begin
      settle_count_in = settle_count_ff;
      reached         = 1'b0;
      if (advance && watched) begin
         if (qualifies) begin
            if (settle_count_ff != '1) begin
               settle_count_in = settle_count_ff + 1'b1;
            end
            reached = (settle_count_in >= settle_needed_ff);
         end else begin
            settle_count_in = '0;
         end
      end
      if (csr_write && (csr_index == dlm_pkg::REG_SETTLE_NEEDED)) begin
         settle_count_in = '0;
      end
   end

   always_comb begin
      out_data_in.charger_off    = charger_off_in;
      out_data_in.discharger_off = discharger_off_in;
      out_data_in.target_reached = reached;
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         charger_off_ff    <= 1'b0;
         discharger_off_ff <= 1'b0;
         settle_count_ff   <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         charger_off_ff    <= charger_off_in;
         discharger_off_ff <= discharger_off_in;
         settle_count_ff   <= settle_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_limit_ff       <= dlm_pkg::LIMIT_OFF;
         high_limit_ff      <= 16'sh7FFF;
         cutoff_limit_ff    <= 16'sh7FFF;
         target_level_ff    <= '0;
         watched_channel_ff <= 1'b0;
         settle_needed_ff   <= '0;
         run_direction_ff   <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            dlm_pkg::REG_LOW_LIMIT:       low_limit_ff       <= csr_data;
            dlm_pkg::REG_HIGH_LIMIT:      high_limit_ff      <= csr_data;
            dlm_pkg::REG_CUTOFF_LIMIT:    cutoff_limit_ff    <= csr_data;
            dlm_pkg::REG_TARGET_LEVEL:    target_level_ff    <= csr_data;
            dlm_pkg::REG_WATCHED_CHANNEL: watched_channel_ff <= csr_data[0];
            dlm_pkg::REG_SETTLE_NEEDED:   settle_needed_ff   <= csr_data;
            dlm_pkg::REG_RUN_DIRECTION:   run_direction_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

### sv/dlm_checker.sv
// ----------------------------------------------------------------------------
// dlm_checker
// Port-level checks of the debounced limit monitor, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "debounced_limit_monitor_defines.svh"

module dlm_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire dlm_pkg::rsp_payload_type rsp_data
);

   // held result beat stays put
   `DLM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // input backs up only behind an unaccepted result
   `DLM_ASSERT_NOW(a_req_stall, !req_ready, rsp_valid && !rsp_ready)

   // a fresh result comes from a sample that passed through the input register
   `DLM_ASSERT_NOW(a_rsp_origin, $rose(rsp_valid), $past(req_valid && req_ready, 2))

   // the first edge after reset shows no result
   `DLM_ASSERT_NOW(a_rsp_reset, $past(reset), !rsp_valid)

endmodule

bind debounced_limit_monitor dlm_checker u_dlm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### bench/tb_debounced_limit_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_debounced_limit_monitor
// Drives sample beats in random bursts, stalls the result side on its own
// pattern, and checks every result beat against a local predictor of the
// debounce counters, sticky flags and run-to-target settle counter.
// ----------------------------------------------------------------------------

module tb_debounced_limit_monitor;

   localparam logic [dlm_pkg::CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;
   localparam int STALL_LIMIT = 2000;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_PULSE,
      READY_RARE
   } ready_mode_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   dlm_pkg::req_payload_type        req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   dlm_pkg::rsp_payload_type        rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [dlm_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [dlm_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   debounced_limit_monitor u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor copy of the registers and state
   logic signed [dlm_pkg::SAMPLE_W-1:0] low_lim    = dlm_pkg::LIMIT_OFF;
   logic signed [dlm_pkg::SAMPLE_W-1:0] high_lim   = 16'sh7fff;
   logic signed [dlm_pkg::SAMPLE_W-1:0] cut_lim    = 16'sh7fff;
   logic signed [dlm_pkg::SAMPLE_W-1:0] target_lvl = '0;
   logic                                watch_ch   = 1'b0;
   logic [dlm_pkg::SETTLE_W-1:0]        settle_goal = '0;
   logic                                run_down   = 1'b0;

   logic [dlm_pkg::CNT_W-1:0]    under_run  = '0;
   logic [dlm_pkg::CNT_W-1:0]    over_run   = '0;
   logic [dlm_pkg::CNT_W-1:0]    cutoff_run = '0;
   logic [dlm_pkg::SETTLE_W-1:0] settle_run = '0;
   logic                         chg_off    = 1'b0;
   logic                         dis_off    = 1'b0;

   dlm_pkg::req_payload_type sample_queue[$];
   dlm_pkg::rsp_payload_type flags_due[$];
   int                       fail_count = 0;

   function automatic void apply_csr(input logic [dlm_pkg::CSR_INDEX_W-1:0] idx,
                                     input logic [dlm_pkg::CSR_DATA_W-1:0] val);
      case (idx)
         dlm_pkg::REG_LOW_LIMIT:       low_lim = val;
         dlm_pkg::REG_HIGH_LIMIT:      high_lim = val;
         dlm_pkg::REG_CUTOFF_LIMIT:    cut_lim = val;
         dlm_pkg::REG_TARGET_LEVEL:    target_lvl = val;
         dlm_pkg::REG_WATCHED_CHANNEL: watch_ch = val[0];
         dlm_pkg::REG_SETTLE_NEEDED: begin
            settle_goal = val;
            settle_run = '0;
         end
         dlm_pkg::REG_RUN_DIRECTION:   run_down = val[0];
         default: ;
      endcase
   endfunction

   function automatic dlm_pkg::rsp_payload_type next_flags(
         input dlm_pkg::req_payload_type beat);
      logic signed [dlm_pkg::SAMPLE_W-1:0] s;
      logic                                hit;
      dlm_pkg::rsp_payload_type            r;
      s = beat.sample;
      r = '0;
      if (beat.channel) begin
         if (low_lim != dlm_pkg::LIMIT_OFF && s < low_lim) begin
            if (under_run >= dlm_pkg::ALARM_DEBOUNCE) dis_off = 1'b1;
            else under_run = under_run + 1'b1;
         end else begin
            under_run = '0;
            dis_off = 1'b0;
         end
         if (high_lim != dlm_pkg::LIMIT_OFF && s > high_lim) begin
            if (over_run >= dlm_pkg::ALARM_DEBOUNCE) chg_off = 1'b1;
            else over_run = over_run + 1'b1;
         end else begin
            over_run = '0;
            chg_off = 1'b0;
         end
         // cutoff last: its set overrides a clear from the other two
         if (cut_lim != dlm_pkg::LIMIT_OFF) begin
            if (s < cut_lim) begin
               if (cutoff_run >= dlm_pkg::ALARM_DEBOUNCE) begin
                  chg_off = 1'b1;
                  dis_off = 1'b1;
               end else begin
                  cutoff_run = cutoff_run + 1'b1;
               end
            end else begin
               cutoff_run = '0;
            end
         end
      end
      if (beat.channel == watch_ch) begin
         hit = run_down ? (s <= target_lvl) : (s >= target_lvl);
         if (hit) begin
            if (settle_run != '1) settle_run = settle_run + 1'b1;
            r.target_reached = (settle_run >= settle_goal);
         end else begin
            settle_run = '0;
         end
      end
      r.charger_off = chg_off;
      r.discharger_off = dis_off;
      return r;
   endfunction

   // Sender: bursts of random length separated by random gaps
   int gap_left = 0;
   int burst_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
         burst_left = 0;
      end else begin
         if (req_valid && req_ready) flags_due.push_back(next_flags(req_data));
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left = gap_left - 1;
               req_valid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
               req_valid <= 1'b1;
               req_data <= sample_queue.pop_front();
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
               end else begin
                  burst_left = burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall pattern switches among a few modes, checks each beat
   ready_mode_type ready_mode = READY_ALWAYS;
   int             mode_left = 0;
   int             pulse_cnt = 0;

   always @(posedge clock) begin
      dlm_pkg::rsp_payload_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         mode_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (flags_due.size() == 0) begin
               $error("result beat with no expectation waiting");
               fail_count++;
            end else begin
               want = flags_due.pop_front();
               if (rsp_data.charger_off !== want.charger_off) begin
                  $error("charger_off: expected %0b, got %0b",
                         want.charger_off, rsp_data.charger_off);
                  fail_count++;
               end
               if (rsp_data.discharger_off !== want.discharger_off) begin
                  $error("discharger_off: expected %0b, got %0b",
                         want.discharger_off, rsp_data.discharger_off);
                  fail_count++;
               end
               if (rsp_data.target_reached !== want.target_reached) begin
                  $error("target_reached: expected %0b, got %0b",
                         want.target_reached, rsp_data.target_reached);
                  fail_count++;
               end
            end
         end
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 120);
         end
         mode_left = mode_left - 1;
         pulse_cnt = pulse_cnt + 1;
         case (ready_mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            READY_PULSE:  rsp_ready <= (pulse_cnt % 7) >= 3;
            default:      rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Watchdog on cycles with no beat on any channel
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_debounced_limit_monitor failed");
            $finish;
         end
      end
   end

   function automatic logic signed [dlm_pkg::SAMPLE_W-1:0] clamp16(input int v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[dlm_pkg::SAMPLE_W-1:0];
   endfunction

   function automatic void add_sample(input int s, input logic ch);
      dlm_pkg::req_payload_type p;
      p.sample = clamp16(s);
      p.channel = ch;
      sample_queue.push_back(p);
   endfunction

   function automatic int pick_level();
      case ($urandom_range(0, 5))
         0:       return -32768;
         1:       return 32767;
         2:       return -32767;
         default: return int'($urandom_range(0, 400)) - 200;
      endcase
   endfunction

   task automatic csr_write(input logic [dlm_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [dlm_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, val);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (sample_queue.size() != 0 || req_valid || flags_due.size() != 0);
   endtask

   initial begin
      int n;
      int len;
      int lvl;
      int pick;
      int ofs;
      logic dn;
      logic ch;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: low off, cutoff at max trips on almost anything
      csr_write(REG_UNUSED, 16'h5a5a);
      repeat (5) add_sample(-32768, 1'b1);
      add_sample(32767, 1'b0);
      add_sample(-1, 1'b0);
      add_sample(32767, 1'b1);
      wait_drained();

      // low and high trip in turn, boundary samples, other channel
      csr_write(dlm_pkg::REG_LOW_LIMIT, 16'hff9c);
      csr_write(dlm_pkg::REG_HIGH_LIMIT, 16'd100);
      csr_write(dlm_pkg::REG_CUTOFF_LIMIT, dlm_pkg::LIMIT_OFF);
      csr_write(dlm_pkg::REG_TARGET_LEVEL, 16'd5);
      csr_write(dlm_pkg::REG_WATCHED_CHANNEL, 16'd1);
      csr_write(dlm_pkg::REG_SETTLE_NEEDED, 16'd3);
      csr_write(dlm_pkg::REG_RUN_DIRECTION, 16'd1);
      repeat (5) add_sample(-101, 1'b1);
      add_sample(0, 1'b1);
      repeat (5) add_sample(101, 1'b1);
      add_sample(-100, 1'b1);
      add_sample(100, 1'b0);
      wait_drained();

      // long qualifying run on channel 0 past the settle goal
      csr_write(dlm_pkg::REG_TARGET_LEVEL, dlm_pkg::LIMIT_OFF);
      csr_write(dlm_pkg::REG_RUN_DIRECTION, 16'd0);
      csr_write(dlm_pkg::REG_WATCHED_CHANNEL, 16'd0);
      csr_write(dlm_pkg::REG_SETTLE_NEEDED, 16'd30);
      repeat (40) add_sample(int'($urandom_range(0, 65535)) - 32768, 1'b0);
      wait_drained();

      for (int ph = 0; ph < 8; ph++) begin
         csr_write(dlm_pkg::REG_LOW_LIMIT, clamp16(pick_level()));
         csr_write(dlm_pkg::REG_HIGH_LIMIT, clamp16(pick_level()));
         csr_write(dlm_pkg::REG_CUTOFF_LIMIT, clamp16(pick_level()));
         csr_write(dlm_pkg::REG_TARGET_LEVEL, clamp16(pick_level()));
         csr_write(dlm_pkg::REG_WATCHED_CHANNEL, 16'($urandom_range(0, 1)));
         csr_write(dlm_pkg::REG_SETTLE_NEEDED, ($urandom_range(0, 7) == 0) ?
                   16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 6)));
         csr_write(dlm_pkg::REG_RUN_DIRECTION, 16'($urandom_range(0, 1)));
         n = 0;
         while (n < 55) begin
            pick = $urandom_range(0, 9);
            len = $urandom_range(1, 8);
            if (pick >= 7) begin
               // noise over the whole range
               repeat (len) add_sample(int'($urandom_range(0, 65535)) - 32768,
                                       1'($urandom_range(0, 1)));
            end else begin
               if (pick < 3) begin
                  lvl = low_lim;
                  dn = 1'b1;
               end else if (pick < 5) begin
                  lvl = high_lim;
                  dn = 1'b0;
               end else if (pick == 5) begin
                  lvl = cut_lim;
                  dn = 1'b1;
               end else begin
                  lvl = target_lvl;
                  dn = 1'($urandom_range(0, 1));
               end
               // runs on one side of a level, zero offset hits the boundary
               repeat (len) begin
                  ofs = $urandom_range(0, 40);
                  if (pick == 6) ch = ($urandom_range(0, 4) == 0) ? ~watch_ch : watch_ch;
                  else ch = ($urandom_range(0, 4) != 0);
                  add_sample(dn ? lvl - ofs : lvl + ofs, ch);
               end
            end
            n = n + len;
         end
         wait_drained();
      end

      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_debounced_limit_monitor passed");
      end else begin
         $display("tb_debounced_limit_monitor failed");
      end
      $finish;
   end

endmodule

### debounced_limit_monitor.f
+incdir+sv
sv/dlm_pkg.sv
sv/dlm_check.sv
sv/debounced_limit_monitor.sv
sv/dlm_checker.sv
bench/tb_debounced_limit_monitor.sv
